// ----- hdl/swtm_pkg.sv -----
// shared constants and types for the sliding window throughput meter
`default_nettype none

package swtm_pkg;

	localparam int WINDOW_DEPTH_DEF = 64;

	localparam int AMOUNT_W = 32;
	localparam int STAMP_W  = 48;
	localparam int RATE_W   = 48;
	localparam int WS_W     = 8;

	localparam int WS_RESET = 5;
	localparam int MS_PER_S = 1000;

	// eviction threshold in ms, (window_seconds + 1) * 1000, at most 256000
	localparam int THR_W     = 18;
	localparam int THR_RESET = (WS_RESET + 1) * MS_PER_S;

	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

	// transaction opcodes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DROP_RD,
		S_DROP,
		S_APPEND,
		S_EV_RD,
		S_EV_SPAN,
		S_EV_CHK,
		S_MUL,
		S_DIV_GO,
		S_DIV_WAIT,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/swtm_div.sv -----
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module swtm_div #(
	parameter int DVD_W = 48
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [DVD_W-1:0]            dividend,
	input  wire logic [swtm_pkg::STAMP_W-1:0] divisor,
	output logic                             done,
	output logic [DVD_W-1:0]                 quotient
);

	localparam int DS_W  = swtm_pkg::STAMP_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DS_W-1:0]  dvs_q;
	logic [DS_W-1:0]  rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DS_W:0]    rem_sh;
	logic [DS_W+1:0]  diff;
	logic             ge;

	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = ~diff[DS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DS_W-1:0] : rem_sh[DS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

// ----- hdl/sliding_window_throughput_meter_top.sv -----
// sliding window throughput meter: sample rings, eviction sequencer, rate divide
// a clear goes straight to the result; an add appends, checks for eviction, multiplies and
//   divides (DVD_W = 42 + log2 depth, 48 at depth 64), with a read and check per evicted
//   entry and a drop first when the ring is full; a zero rate skips the bit-serial divide
// one transaction at a time, accepted again once the result register loads
// reset: arst_n clears the window (empty, sum 0) and sets window_seconds to 5
`default_nettype none

module sliding_window_throughput_meter_top #(
	parameter int WINDOW_DEPTH = swtm_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// config register
	input  wire logic                                cfg_we,
	input  wire logic [swtm_pkg::WS_W-1:0]           cfg_wdata,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                op,
	input  wire logic [swtm_pkg::AMOUNT_W-1:0]       amount,
	input  wire logic [swtm_pkg::STAMP_W-1:0]        stamp_ms,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [swtm_pkg::RATE_W-1:0]              rate,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0]        entries_held
);

	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int CW    = $clog2(WINDOW_DEPTH + 1);
	localparam int SW    = swtm_pkg::AMOUNT_W + AW;   // sum of all held sizes
	localparam int DVD_W = SW + 10;                   // sum times 1000
	localparam int QW    = (DVD_W > swtm_pkg::RATE_W) ? DVD_W : swtm_pkg::RATE_W;
	localparam int TW    = swtm_pkg::STAMP_W;
	localparam int THR_W = swtm_pkg::THR_W;

	// sample rings, read data registered
	logic [swtm_pkg::AMOUNT_W-1:0] size_mem [WINDOW_DEPTH];
	logic [TW-1:0]                 time_mem [WINDOW_DEPTH];

	swtm_pkg::state_t state_q, state_nxt;

	logic [AW-1:0]  head_q;
	logic [CW-1:0]  count_q;
	logic [SW-1:0]  sum_q;
	logic [THR_W-1:0] thr_q;

	logic [swtm_pkg::AMOUNT_W-1:0] amount_q;
	logic [TW-1:0]                 stamp_q;

	logic [swtm_pkg::AMOUNT_W-1:0] size_old_q;
	logic [TW-1:0]                 time_old_q;
	logic [TW-1:0]                 time_new_q;
	logic [TW:0]                   span_q;      // signed newest minus oldest

	logic [DVD_W-1:0]          prod_q;
	logic [swtm_pkg::RATE_W-1:0] res_rate_q;

	logic                        out_valid_q;
	logic [swtm_pkg::RATE_W-1:0] out_rate_q;
	logic [CW-1:0]               out_held_q;

	// sequencer outputs
	logic mem_we;
	logic div_start;
	logic out_load;

	logic evict;
	logic zero_rate;
	logic full;

	logic [AW-1:0] head_inc;
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail_slot;
	logic [AW:0]   newest_sum;
	logic [AW-1:0] newest_slot;

	logic [SW-1:0]    sum_less_old;
	logic [DVD_W-1:0] mul_in;

	logic             div_done;
	logic [DVD_W-1:0] div_quot;
	logic [QW-1:0]    quot_ext;
	logic [swtm_pkg::RATE_W-1:0] rate_sat;

	// ring pointer arithmetic, wraps at any depth
	assign head_inc = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);

	assign tail_sum  = {1'b0, head_q} + (AW+1)'(count_q);
	assign tail_slot = (tail_sum >= (AW+1)'(WINDOW_DEPTH)) ?
		AW'(tail_sum - (AW+1)'(WINDOW_DEPTH)) : AW'(tail_sum);

	assign newest_sum  = tail_sum - (AW+1)'(1);
	assign newest_slot = (newest_sum >= (AW+1)'(WINDOW_DEPTH)) ?
		AW'(newest_sum - (AW+1)'(WINDOW_DEPTH)) : AW'(newest_sum);

	assign full = (count_q == CW'(WINDOW_DEPTH));

	// evict while newest - oldest >= threshold, a negative span never evicts
	assign evict = (count_q != '0) && !span_q[TW] && (span_q[TW-1:0] >= TW'(thr_q));

	// no rate with fewer than two entries or a span that is not positive
	assign zero_rate = (count_q < CW'(2)) || span_q[TW] || (span_q[TW-1:0] == '0);

	// sum of all but the oldest, times 1000 as (x << 10) - (x << 4) - (x << 3)
	assign sum_less_old = sum_q - SW'(size_old_q);
	assign mul_in       = DVD_W'(sum_less_old);

	// saturate the quotient to the rate width
	assign quot_ext = QW'(div_quot);
	assign rate_sat = (quot_ext > QW'(swtm_pkg::RATE_MAX)) ?
		swtm_pkg::RATE_MAX : quot_ext[swtm_pkg::RATE_W-1:0];

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			swtm_pkg::S_IDLE: begin
				if (in_valid) begin
					if (op == swtm_pkg::OP_CLEAR) begin
						state_nxt = swtm_pkg::S_DONE;
					end else if (full) begin
						state_nxt = swtm_pkg::S_DROP_RD;
					end else begin
						state_nxt = swtm_pkg::S_APPEND;
					end
				end
			end
			swtm_pkg::S_DROP_RD:  state_nxt = swtm_pkg::S_DROP;
			swtm_pkg::S_DROP:     state_nxt = swtm_pkg::S_APPEND;
			swtm_pkg::S_APPEND:   state_nxt = swtm_pkg::S_EV_RD;
			swtm_pkg::S_EV_RD:    state_nxt = swtm_pkg::S_EV_SPAN;
			swtm_pkg::S_EV_SPAN:  state_nxt = swtm_pkg::S_EV_CHK;
			swtm_pkg::S_EV_CHK: begin
				priority if (evict) begin
					state_nxt = swtm_pkg::S_EV_RD;
				end else if (zero_rate) begin
					state_nxt = swtm_pkg::S_DONE;
				end else begin
					state_nxt = swtm_pkg::S_MUL;
				end
			end
			swtm_pkg::S_MUL:      state_nxt = swtm_pkg::S_DIV_GO;
			swtm_pkg::S_DIV_GO:   state_nxt = swtm_pkg::S_DIV_WAIT;
			swtm_pkg::S_DIV_WAIT: begin
				if (div_done) begin
					state_nxt = swtm_pkg::S_DONE;
				end
			end
			swtm_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = swtm_pkg::S_IDLE;
				end
			end
			default: state_nxt = swtm_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			swtm_pkg::S_IDLE:     in_ready  = 1'b1;
			swtm_pkg::S_APPEND:   mem_we    = 1'b1;
			swtm_pkg::S_DIV_GO:   div_start = 1'b1;
			swtm_pkg::S_DONE:     out_load  = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swtm_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// config: keep the threshold in ms rather than the seconds value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(swtm_pkg::THR_RESET);
		end else if (cfg_we) begin
			thr_q <= THR_W'({1'b0, cfg_wdata} + 9'd1) * THR_W'(swtm_pkg::MS_PER_S);
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				swtm_pkg::S_IDLE: begin
					if (in_valid && op == swtm_pkg::OP_CLEAR) begin
						head_q  <= '0;
						count_q <= '0;
						sum_q   <= '0;
					end
				end
				swtm_pkg::S_DROP: begin
					sum_q   <= sum_q - SW'(size_old_q);
					head_q  <= head_inc;
					count_q <= count_q - CW'(1);
				end
				swtm_pkg::S_APPEND: begin
					sum_q   <= sum_q + SW'(amount_q);
					count_q <= count_q + CW'(1);
				end
				swtm_pkg::S_EV_CHK: begin
					if (evict) begin
						sum_q   <= sum_q - SW'(size_old_q);
						head_q  <= head_inc;
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload capture, rings and arithmetic registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			amount_q <= amount;
			stamp_q  <= stamp_ms;
		end
		if (mem_we) begin
			size_mem[tail_slot] <= amount_q;
			time_mem[tail_slot] <= stamp_q;
		end
		size_old_q <= size_mem[head_q];
		time_old_q <= time_mem[head_q];
		time_new_q <= time_mem[newest_slot];
		if (state_q == swtm_pkg::S_EV_SPAN) begin
			span_q <= {1'b0, time_new_q} - {1'b0, time_old_q};
		end
		if (state_q == swtm_pkg::S_MUL) begin
			prod_q <= (mul_in << 10) - (mul_in << 4) - (mul_in << 3);
		end
		if (state_q == swtm_pkg::S_IDLE ||
				(state_q == swtm_pkg::S_EV_CHK && !evict && zero_rate)) begin
			res_rate_q <= '0;
		end else if (state_q == swtm_pkg::S_DIV_WAIT && div_done) begin
			res_rate_q <= rate_sat;
		end
	end

	swtm_div #(
		.DVD_W (DVD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (span_q[TW-1:0]),
		.done     (div_done),
		.quotient (div_quot)
	);

	// result register, frees the sequencer while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rate_q <= res_rate_q;
			out_held_q <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign rate         = out_rate_q;
	assign entries_held = out_held_q;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// testbench for the sliding window throughput meter: stimulus, driver, monitor and rate predictor
module tb;
	import swtm_pkg::*;

	localparam int DEPTH        = WINDOW_DEPTH_DEF;
	localparam int HELD_W       = $clog2(DEPTH + 1);
	localparam int IDLE_LIMIT   = 5000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic                op;
		logic [AMOUNT_W-1:0] amount;
		logic [STAMP_W-1:0]  stamp;
	} sample_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [HELD_W-1:0] held;
	} reading_t;

	// every input is known from time zero
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [WS_W-1:0]     cfg_wdata = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic                op        = OP_ADD;
	logic [AMOUNT_W-1:0] amount    = '0;
	logic [STAMP_W-1:0]  stamp_ms  = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [RATE_W-1:0]   rate;
	logic [HELD_W-1:0]   entries_held;

	sliding_window_throughput_meter_top #(
		.WINDOW_DEPTH(DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.amount       (amount),
		.stamp_ms     (stamp_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rate         (rate),
		.entries_held (entries_held)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// rate predictor: its own copy of the sample window
	// ------------------------------------------------------------------
	logic [AMOUNT_W-1:0] win_size [DEPTH];
	logic [STAMP_W-1:0]  win_time [DEPTH];
	int                  win_head    = 0;
	int                  win_count   = 0;
	logic [63:0]         win_total   = '0;
	logic [WS_W-1:0]     window_secs = WS_W'(WS_RESET);

	// run statistics for the summary
	int evictions_seen = 0;
	int ring_drops     = 0;
	int samples_added  = 0;
	int clears_sent    = 0;
	int settings_used  = 0;
	int long_holds     = 0;

	function automatic void drop_oldest_sample();
		win_total = win_total - 64'(win_size[win_head]);
		win_head  = (win_head + 1) % DEPTH;
		win_count--;
	endfunction

	// signed distance from the oldest to the newest held stamp
	function automatic longint window_span();
		logic [STAMP_W-1:0] newest;
		newest = win_time[(win_head + win_count - 1) % DEPTH];
		return longint'({16'd0, newest}) - longint'({16'd0, win_time[win_head]});
	endfunction

	function automatic reading_t predict_reading(sample_t s);
		reading_t    r;
		longint      limit_ms;
		longint      span;
		logic [63:0] moved;
		logic [63:0] bps;
		int          slot;
		if (s.op == OP_CLEAR) begin
			win_head  = 0;
			win_count = 0;
			win_total = '0;
		end else begin
			limit_ms = (longint'(window_secs) + 1) * MS_PER_S;
			// a full ring loses its oldest sample before the append
			if (win_count >= DEPTH) begin
				drop_oldest_sample();
				ring_drops++;
			end
			slot           = (win_head + win_count) % DEPTH;
			win_size[slot] = s.amount;
			win_time[slot] = s.stamp;
			win_count++;
			win_total      = win_total + 64'(s.amount);
			// evict while the span still reaches the window, rechecking each time
			while (win_count > 0 && window_span() >= limit_ms) begin
				drop_oldest_sample();
				evictions_seen++;
			end
		end
		r.rate = '0;
		r.held = HELD_W'(win_count);
		if (win_count >= 2) begin
			span = window_span();
			if (span > 0) begin
				// the oldest sample only marks the start of the span
				moved  = win_total - 64'(win_size[win_head]);
				bps    = (moved * 64'd1000) / 64'(span);
				r.rate = (bps > 64'(RATE_MAX)) ? RATE_MAX : bps[RATE_W-1:0];
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// monitor: sampled at the rising edge, before the block's own updates land
	// ------------------------------------------------------------------
	reading_t expected_readings [$];
	reading_t oldest_reading;
	int       accepted_count = 0;
	int       pushed_count   = 0;
	int       error_count    = 0;
	logic     in_taken       = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken = 1'b0;
		end else begin
			// result transaction, checked against the oldest open prediction
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual rate %0d entries_held %0d",
						$time, rate, entries_held);
					error_count++;
				end else begin
					oldest_reading = expected_readings.pop_front();
					if (rate !== oldest_reading.rate) begin
						$display("%0t: rate mismatch, expected %0d, actual %0d",
							$time, oldest_reading.rate, rate);
						error_count++;
					end
					if (entries_held !== oldest_reading.held) begin
						$display("%0t: entries_held mismatch, expected %0d, actual %0d",
							$time, oldest_reading.held, entries_held);
						error_count++;
					end
				end
			end
			// input transaction, predicted at the edge that takes it
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				expected_readings.push_back(predict_reading(sample_t'{op, amount, stamp_ms}));
				accepted_count++;
				if (op == OP_CLEAR)
					clears_sent++;
				else
					samples_added++;
			end
		end
	end

	// ------------------------------------------------------------------
	// driver: feeds pending samples at the falling edge, with idle bursts
	// ------------------------------------------------------------------
	sample_t pending_samples [$];
	sample_t next_sample;
	int      send_gap = 0;
	logic    calm     = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				next_sample = pending_samples.pop_front();
				op       <= next_sample.op;
				amount   <= next_sample.amount;
				stamp_ms <= next_sample.stamp;
				in_valid <= 1'b1;
				// sometimes idle for a burst once this transaction is taken
				if (!calm && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 19);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stall bursts, plus one long hold-off on request
	// ------------------------------------------------------------------
	int   hold_left     = 0;
	logic long_hold_req = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left     = LONG_HOLD - 1;
			long_holds++;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(0, 18);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too many cycles without any transaction ends the run
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("sliding_window_throughput_meter_top test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	logic [STAMP_W-1:0] clock_ms;

	task automatic queue_sample(input logic kind, input logic [AMOUNT_W-1:0] amt,
		input logic [STAMP_W-1:0] st);
		pending_samples.push_back(sample_t'{kind, amt, st});
		pushed_count++;
	endtask

	// returns at a falling edge once every transaction is taken and answered
	task automatic wait_drained();
		do
			@(negedge clk);
		while (accepted_count != pushed_count || expected_readings.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// only called with the block idle; the predictor follows at once
	task automatic write_window(input logic [WS_W-1:0] secs);
		cfg_wdata   <= secs;
		cfg_we      <= 1'b1;
		window_secs = secs;
		settings_used++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [AMOUNT_W-1:0] pick_amount();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(0, 1000);
			default: return $urandom();
		endcase
	endfunction

	// one window setting: mostly forward-moving stamps, spread sets how many
	// samples fit a window; noisy adds clears, stamps going back and big jumps
	task automatic queue_setting(input logic [WS_W-1:0] secs, input int n, input int spread,
		input bit noisy);
		int                 limit_ms;
		int                 pick;
		logic [STAMP_W-1:0] step_ms;
		limit_ms = (int'(secs) + 1) * MS_PER_S;
		write_window(secs);
		case ($urandom_range(0, 3))
			0: clock_ms = '0;
			1: clock_ms = {16'hFFFF, $urandom()};
			default: clock_ms = {16'($urandom()), $urandom()};
		endcase
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (noisy && pick < 4) begin
				queue_sample(OP_CLEAR, $urandom(), {16'($urandom()), $urandom()});
			end else if (noisy && pick < 8) begin
				queue_sample(OP_ADD, pick_amount(),
					clock_ms - STAMP_W'($urandom_range(1, 2 * limit_ms)));
			end else begin
				if (noisy && pick < 12)
					step_ms = STAMP_W'($urandom_range(limit_ms, 3 * limit_ms));
				else if (pick % 10 == 0)
					step_ms = '0;
				else
					step_ms = STAMP_W'($urandom_range(0, 2 * limit_ms / spread));
				clock_ms = clock_ms + step_ms;
				queue_sample(OP_ADD, pick_amount(), clock_ms);
			end
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at the reset window of 5 s (6000 ms threshold)
		queue_sample(OP_CLEAR, '1, '1);                // clear of an empty window, junk fields
		queue_sample(OP_ADD, '0, '0);                  // single sample, zero amount
		queue_sample(OP_ADD, '1, '0);                  // zero span
		queue_sample(OP_ADD, '1, 48'd1);               // one ms span, large rate
		queue_sample(OP_ADD, 32'd12345, 48'd5999);     // just inside the window
		queue_sample(OP_ADD, 32'd7, 48'd6000);         // span hits the threshold, two evicted
		queue_sample(OP_ADD, 32'd1, 48'd0);            // stamp going back, negative span
		queue_sample(OP_ADD, 32'd100, '1);             // top stamp evicts all but itself
		queue_sample(OP_ADD, 32'h5555_5555, '1);       // repeated top stamp
		queue_sample(OP_ADD, 32'hAAAA_AAAA, '0);       // large negative span
		queue_sample(OP_CLEAR, '0, '0);
		queue_sample(OP_ADD, 32'd1000, 48'd1000);
		queue_sample(OP_ADD, 32'd2000, 48'd1500);      // plain 4000 bytes per second
		queue_sample(OP_CLEAR, $urandom(), {16'($urandom()), $urandom()});
		wait_drained();

		// random part over several window settings, extremes among them
		queue_setting(8'd0, 145, 8, 1'b1);
		wait_drained();
		// dense stamps keep the ring full; the receiver holds off meanwhile
		queue_setting(8'd255, 160, 100, 1'b0);
		long_hold_req = 1'b1;
		wait_drained();
		queue_setting(8'd1, 145, 2, 1'b1);
		wait_drained();
		queue_setting(WS_W'($urandom_range(2, 254)), 145, 40, 1'b1);
		wait_drained();
		queue_setting(WS_W'($urandom_range(2, 254)), 145, 100, 1'b1);
		wait_drained();
		queue_setting(8'd255, 145, 8, 1'b1);
		wait_drained();
		// last stretch back at 5 s, no idling on either side
		calm = 1'b1;
		queue_setting(8'd5, 145, 40, 1'b1);
		wait_drained();

		// a stray result would still show up here
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_readings.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_readings.size());
			error_count++;
		end

		$display("ran %0d samples and %0d clears over %0d window settings",
			samples_added, clears_sent, settings_used);
		$display("saw %0d evictions, %0d full-ring drops, %0d long receiver hold-offs",
			evictions_seen, ring_drops, long_holds);
		if (error_count == 0) begin
			$display("sliding_window_throughput_meter_top test passed");
		end else begin
			$display("sliding_window_throughput_meter_top test failed");
		end
		$finish;
	end

endmodule

// ----- sliding_window_throughput_meter_top.f -----
hdl/swtm_pkg.sv
hdl/swtm_div.sv
hdl/sliding_window_throughput_meter_top.sv
test/tb.sv
